// ===== rtl/smoothstep_polynomial_eval_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Smoothstep evaluator assertion macros
// Shared concurrent assertion forms for the smoothstep evaluator.
// ----------------------------------------------------------------------------
`ifndef SMOOTHSTEP_POLYNOMIAL_EVAL_UNIT_DEFINES_SVH
`define SMOOTHSTEP_POLYNOMIAL_EVAL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// Smoothstep evaluator package
// Widths, Horner program tables and the data beat carried along the cell row.
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W_W       = FRAC_BITS + 1;   // weight, Q0.F with 1.0 included
  localparam int RES_W     = FRAC_BITS + 2;   // result, Q2.F
  localparam int ACC_W     = FRAC_BITS + 11;  // signed accumulator, holds +-280.0
  localparam int KW_W      = 6;               // signed seed coefficient
  localparam int MAX_STEPS = 6;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam logic [W_W-1:0]   W_ONE   = W_W'(1) << FRAC_BITS;
  localparam logic [RES_W-1:0] RES_ONE = RES_W'(1) << FRAC_BITS;
  localparam logic [RES_W-1:0] RES_MAX = '1;

  // {op, level}: op 0 value, op 1 derivative
  typedef enum logic [2:0] {
    PROG_V_LIN = 3'b000,
    PROG_V_CUB = 3'b001,
    PROG_V_QUI = 3'b010,
    PROG_V_SEP = 3'b011,
    PROG_D_LIN = 3'b100,
    PROG_D_CUB = 3'b101,
    PROG_D_QUI = 3'b110,
    PROG_D_SEP = 3'b111
  } spe_prog_e;

  typedef enum logic [1:0] {
    SCALE_NONE = 2'd0,
    SCALE_X30  = 2'd1,
    SCALE_X140 = 2'd2
  } spe_scale_e;

  typedef struct packed {
    logic signed [ACC_W-1:0] add;
    spe_scale_e              scale;
  } spe_step_t;

  typedef struct packed {
    logic signed [KW_W-1:0]  kw;
    logic signed [ACC_W-1:0] c0;
  } spe_seed_t;

  typedef struct packed {
    logic                    op;
    logic [1:0]              level;
    logic [STEP_W-1:0]       step;
    logic [W_W-1:0]          w;
    logic signed [ACC_W-1:0] acc;
  } spe_data_t;

  function automatic logic signed [ACC_W-1:0] k_fx(input int c);
    return ACC_W'(longint'(c) <<< FRAC_BITS);
  endfunction

  function automatic logic [STEP_W-1:0] n_steps(input logic op, input logic [1:0] level);
    logic [STEP_W-1:0] n;
    case (spe_prog_e'({op, level}))
      PROG_V_LIN: n = STEP_W'(0);
      PROG_V_CUB: n = STEP_W'(2);
      PROG_V_QUI: n = STEP_W'(4);
      PROG_V_SEP: n = STEP_W'(6);
      PROG_D_LIN: n = STEP_W'(0);
      PROG_D_CUB: n = STEP_W'(1);
      PROG_D_QUI: n = STEP_W'(3);
      PROG_D_SEP: n = STEP_W'(5);
      default:    n = STEP_W'(0);
    endcase
    return n;
  endfunction

  // Initial accumulator: kw * w + c0
  function automatic spe_seed_t seed_of(input logic op, input logic [1:0] level);
    spe_seed_t s;
    case (spe_prog_e'({op, level}))
      PROG_V_LIN: begin s.kw = KW_W'(1);   s.c0 = k_fx(0);   end
      PROG_V_CUB: begin s.kw = -KW_W'(2);  s.c0 = k_fx(3);   end
      PROG_V_QUI: begin s.kw = KW_W'(6);   s.c0 = k_fx(-15); end
      PROG_V_SEP: begin s.kw = -KW_W'(20); s.c0 = k_fx(70);  end
      PROG_D_LIN: begin s.kw = KW_W'(0);   s.c0 = k_fx(1);   end
      PROG_D_CUB: begin s.kw = -KW_W'(6);  s.c0 = k_fx(6);   end
      PROG_D_QUI: begin s.kw = KW_W'(1);   s.c0 = k_fx(-2);  end
      PROG_D_SEP: begin s.kw = -KW_W'(1);  s.c0 = k_fx(3);   end
      default:    begin s.kw = KW_W'(0);   s.c0 = k_fx(0);   end
    endcase
    return s;
  endfunction

  // Horner step s: acc = (round(acc * w) + add) * scale
  function automatic spe_step_t step_of(input logic op, input logic [1:0] level,
                                        input logic [STEP_W-1:0] s);
    spe_step_t st;
    st.add   = k_fx(0);
    st.scale = SCALE_NONE;
    case (spe_prog_e'({op, level}))
      PROG_V_QUI: begin
        if (s == STEP_W'(0)) st.add = k_fx(10);
      end
      PROG_V_SEP: begin
        if (s == STEP_W'(0)) st.add = k_fx(-84);
        if (s == STEP_W'(1)) st.add = k_fx(35);
      end
      PROG_D_QUI: begin
        if (s == STEP_W'(0)) begin
          st.add   = k_fx(1);
          st.scale = SCALE_X30;
        end
      end
      PROG_D_SEP: begin
        if (s == STEP_W'(0)) st.add = k_fx(-3);
        if (s == STEP_W'(1)) begin
          st.add   = k_fx(1);
          st.scale = SCALE_X140;
        end
      end
      default: begin
        st.add   = k_fx(0);
        st.scale = SCALE_NONE;
      end
    endcase
    return st;
  endfunction

endpackage

// ===== rtl/spe_seed.sv =====
// ----------------------------------------------------------------------------
// Smoothstep evaluator seed stage
// Saturates the weight and forms the first Horner term of the chosen program.
// ----------------------------------------------------------------------------
module spe_seed (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       op_i,
  input  logic [1:0]                 level_i,
  input  logic [spe_pkg::W_W-1:0]    weight_i,
  output logic                       valid_o,
  output spe_pkg::spe_data_t         data_o
);

  logic                                         valid_q;
  spe_pkg::spe_data_t                           data_d, data_q;
  logic [spe_pkg::W_W-1:0]                      w_sat;
  logic signed [spe_pkg::W_W:0]                 w_s;
  logic signed [spe_pkg::W_W+spe_pkg::KW_W:0]   kp;
  spe_pkg::spe_seed_t                           sd;

  always_comb begin
    // clamp weights above one to exactly one
    w_sat       = (weight_i > spe_pkg::W_ONE) ? spe_pkg::W_ONE : weight_i;
    w_s         = $signed({1'b0, w_sat});
    sd          = spe_pkg::seed_of(op_i, level_i);
    kp          = w_s * sd.kw;
    data_d.op    = op_i;
    data_d.level = level_i;
    data_d.step  = '0;
    data_d.w     = w_sat;
    data_d.acc   = spe_pkg::ACC_W'(kp) + sd.c0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/spe_cell.sv =====
// ----------------------------------------------------------------------------
// Smoothstep evaluator Horner cell
// Applies the next pending Horner step of a beat, or passes it on unchanged.
// ----------------------------------------------------------------------------
module spe_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  spe_pkg::spe_data_t  data_i,
  output logic                valid_o,
  output spe_pkg::spe_data_t  data_o
);

  localparam int PROD_W = spe_pkg::ACC_W + spe_pkg::W_W;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (spe_pkg::FRAC_BITS - 1);

  logic                              valid_q;
  spe_pkg::spe_data_t                data_d, data_q;
  spe_pkg::spe_step_t                st;
  logic                              act, neg;
  logic [spe_pkg::ACC_W-1:0]         mag, rnd_mag;
  logic [PROD_W-1:0]                 prod, rnd;
  logic signed [spe_pkg::ACC_W-1:0]  rs, sum, scaled;

  always_comb begin
    act = data_i.step < spe_pkg::n_steps(data_i.op, data_i.level);
    st  = spe_pkg::step_of(data_i.op, data_i.level, data_i.step);
    neg = data_i.acc[spe_pkg::ACC_W-1];
    mag = neg ? (~unsigned'(data_i.acc) + spe_pkg::ACC_W'(1)) : unsigned'(data_i.acc);
    // round to nearest on the magnitude, ties away from zero
    prod    = PROD_W'(mag) * PROD_W'(data_i.w);
    rnd     = (prod + HALF) >> spe_pkg::FRAC_BITS;
    rnd_mag = rnd[spe_pkg::ACC_W-1:0];
    rs      = neg ? -$signed(rnd_mag) : $signed(rnd_mag);
    sum     = rs + st.add;
    case (st.scale)
      spe_pkg::SCALE_NONE: scaled = sum;
      spe_pkg::SCALE_X30:  scaled = (sum <<< 5) - (sum <<< 1);
      spe_pkg::SCALE_X140: scaled = (sum <<< 7) + (sum <<< 3) + (sum <<< 2);
      default:             scaled = sum;
    endcase
    data_d = data_i;
    if (act) begin
      data_d.acc  = scaled;
      data_d.step = data_i.step + spe_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/smoothstep_polynomial_eval_unit.sv =====
// ----------------------------------------------------------------------------
// Smoothstep polynomial evaluator
// Value or derivative of the linear, cubic, quintic or septic smoothstep.
// ----------------------------------------------------------------------------
// Accepts one weight per clock: busy_o is always low, so a beat is taken on
// every cycle start_i is high. Each beat returns exactly one result, strobed on
// valid_o for a single cycle once it has passed the seed stage, six Horner
// cells and output clamp. The receiver cannot stall the pipeline; results
// leave in input order. Weights above 1.0 saturate to 1.0. Value results are
// Q2.16 clamped to [0, 1.0]; derivatives are Q2.16 clamped to [0, Q2 max].
// ----------------------------------------------------------------------------
`include "smoothstep_polynomial_eval_unit_defines.svh"

module smoothstep_polynomial_eval_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        op_i,
  input  logic [1:0]                  level_i,
  input  logic [spe_pkg::W_W-1:0]     weight_i,
  output logic                        valid_o,
  output logic [spe_pkg::RES_W-1:0]   result_o
);

  // seed + cells + output register
  localparam int LATENCY = spe_pkg::MAX_STEPS + 2;

  logic [spe_pkg::MAX_STEPS:0]  cv;
  spe_pkg::spe_data_t           cd [spe_pkg::MAX_STEPS+1];

  logic                         valid_q;
  logic [spe_pkg::RES_W-1:0]    result_d, result_q;
  logic [spe_pkg::ACC_W-1:0]    lim;
  spe_pkg::spe_data_t           last;

  // no backpressure anywhere, so never hold off a beat
  assign busy_o = 1'b0;

  spe_seed u_seed (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .op_i     (op_i),
    .level_i  (level_i),
    .weight_i (weight_i),
    .valid_o  (cv[0]),
    .data_o   (cd[0])
  );

  // Each cell performs the beat's next pending Horner step; programs with
  // fewer steps simply pass through the trailing cells.
  for (genvar i = 0; i < spe_pkg::MAX_STEPS; i++) begin : g_cell
    spe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .data_o  (cd[i+1])
    );
  end

  // Clamp: negatives to zero, values to 1.0, derivatives to the Q2 maximum.
  always_comb begin
    last = cd[spe_pkg::MAX_STEPS];
    lim  = last.op ? spe_pkg::ACC_W'(spe_pkg::RES_MAX) : spe_pkg::ACC_W'(spe_pkg::RES_ONE);
    if (last.acc[spe_pkg::ACC_W-1]) begin
      result_d = '0;
    end else if (unsigned'(last.acc) > lim) begin
      result_d = lim[spe_pkg::RES_W-1:0];
    end else begin
      result_d = last.acc[spe_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cv[spe_pkg::MAX_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  // A result strobe always traces back to an accepted beat.
  `SPE_ASSERT_IMPL(a_strobe_has_source, clk_i, rst_ni, valid_o, $past(start_i, LATENCY), "result without accepted beat")
  // Linear derivative is exactly one.
  `SPE_ASSERT_IMPL(a_lin_deriv_one, clk_i, rst_ni, valid_o && $past(op_i && (level_i == 2'd0), LATENCY), result_o == spe_pkg::RES_ONE, "linear derivative not one")
  // Value results never exceed one.
  `SPE_ASSERT_IMPL(a_value_bound, clk_i, rst_ni, valid_o && !$past(op_i, LATENCY), result_o <= spe_pkg::RES_ONE, "value result above one")

endmodule

// ===== sim/tb_smoothstep_polynomial_eval_unit.sv =====
// ----------------------------------------------------------------------------
// Smoothstep evaluator testbench
// Sends weights with random op, level and gaps into the evaluator. A scoreboard
// class predicts each result in fixed point Horner form. Every strobed result
// is then compared in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_smoothstep_polynomial_eval_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import spe_pkg::*;

  // Fixed point constants of the predictor, Q.FRAC_BITS
  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam longint HALF_Q  = longint'(1) << (FRAC_BITS - 1);
  localparam longint Q2_MAX  = (longint'(1) << (FRAC_BITS + 2)) - 1;
  localparam int     SHOWN   = 40;   // mismatch lines printed before going quiet
  localparam int     N_RAND  = 1850;
  localparam int     MAX_GAP = 17;

  // One beat in flight: what went in and what must come out
  typedef struct {
    logic             op;
    logic [1:0]       level;
    logic [W_W-1:0]   weight;
    logic [RES_W-1:0] result;
  } pending_t;

  class smoothstep_ledger;
    pending_t    pending_results[$];
    int unsigned mismatches = 0;

    task flag_mismatch(string what);
      if (mismatches < SHOWN)
        $display("%0t ns  mismatch: %s", $time, what);
      mismatches++;
    endtask

    // a * w / 2^FRAC_BITS, rounded to nearest with ties away from zero
    function longint mul_w(longint a, longint w);
      bit     neg;
      longint m;
      longint r;
      neg = (a < 0);
      m   = neg ? -a : a;
      r   = (m >> FRAC_BITS) * w + ((((ONE_Q - 1) & m) * w + HALF_Q) >> FRAC_BITS);
      return neg ? -r : r;
    endfunction

    function logic [RES_W-1:0] smoothstep_of(logic op, logic [1:0] level,
                                             logic [W_W-1:0] weight);
      longint w;
      longint a;
      longint r;
      longint lim;
      w = longint'(weight);
      if (w > ONE_Q) w = ONE_Q;
      case (spe_prog_e'({op, level}))
        PROG_V_LIN: r = w;
        PROG_V_CUB: begin
          a = mul_w(-2 * ONE_Q, w) + 3 * ONE_Q;
          a = mul_w(a, w);
          r = mul_w(a, w);
        end
        PROG_V_QUI: begin
          a = mul_w(6 * ONE_Q, w) - 15 * ONE_Q;
          a = mul_w(a, w) + 10 * ONE_Q;
          a = mul_w(a, w);
          a = mul_w(a, w);
          r = mul_w(a, w);
        end
        PROG_V_SEP: begin
          a = mul_w(-20 * ONE_Q, w) + 70 * ONE_Q;
          a = mul_w(a, w) - 84 * ONE_Q;
          a = mul_w(a, w) + 35 * ONE_Q;
          a = mul_w(a, w);
          a = mul_w(a, w);
          a = mul_w(a, w);
          r = mul_w(a, w);
        end
        PROG_D_LIN: r = ONE_Q;
        PROG_D_CUB: begin
          a = mul_w(-6 * ONE_Q, w) + 6 * ONE_Q;
          r = mul_w(a, w);
        end
        PROG_D_QUI: begin
          a = w - 2 * ONE_Q;
          a = (mul_w(a, w) + ONE_Q) * 30;
          a = mul_w(a, w);
          r = mul_w(a, w);
        end
        default: begin
          a = 3 * ONE_Q - w;
          a = mul_w(a, w) - 3 * ONE_Q;
          a = (mul_w(a, w) + ONE_Q) * 140;
          a = mul_w(a, w);
          a = mul_w(a, w);
          r = mul_w(a, w);
        end
      endcase
      lim = op ? Q2_MAX : ONE_Q;
      if (r < 0) r = 0;
      if (r > lim) r = lim;
      return r[RES_W-1:0];
    endfunction

    function void take_weight(logic op, logic [1:0] level, logic [W_W-1:0] weight);
      pending_t p;
      p.op     = op;
      p.level  = level;
      p.weight = weight;
      p.result = smoothstep_of(op, level, weight);
      pending_results.push_back(p);
    endfunction

    task match_result(logic [RES_W-1:0] got);
      pending_t p;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result 0x%05h with no beat pending", got));
      end else begin
        p = pending_results.pop_front();
        if (got !== p.result)
          flag_mismatch($sformatf("op %0d level %0d weight 0x%05h: got 0x%05h want 0x%05h",
                                  p.op, p.level, p.weight, got, p.result));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic             op_i;
  logic [1:0]       level_i;
  logic [W_W-1:0]   weight_i;
  logic             valid_o;
  logic [RES_W-1:0] result_o;

  smoothstep_ledger ledger = new;
  int unsigned      back_to_back = 0;   // beats left in the current no-gap stretch

  smoothstep_polynomial_eval_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .op_i     (op_i),
    .level_i  (level_i),
    .weight_i (weight_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // 2 ns clock: low half, then high half
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hold start low for the given gap; inputs only move at the falling edge
  task idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Present one beat and wait for the edge that takes it (start high, busy low).
  // Leave start high afterwards so a back-to-back beat never drops it.
  task send_beat(logic op, logic [1:0] level, logic [W_W-1:0] weight);
    @(negedge clk_i);
    start_i  <= 1'b1;
    op_i     <= op;
    level_i  <= level;
    weight_i <= weight;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    ledger.take_weight(op, level, weight);
  endtask

  // Draw the sender's gap: mostly a uniform random idle gap, with stretches of none at all
  function automatic int unsigned draw_gap();
    if (back_to_back == 0 && $urandom_range(0, 39) == 0)
      back_to_back = $urandom_range(10, 60);
    if (back_to_back != 0) begin
      back_to_back--;
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Mostly legal weights, some saturating ones, some right at the corners
  function automatic logic [W_W-1:0] draw_weight();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return W_W'($urandom_range(0, int'(W_ONE)));
      6: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return W_W'(1);
          2: return W_ONE - W_W'(1);
          3: return W_ONE;
          4: return W_ONE + W_W'(1);
          default: return '1;
        endcase
      end
      7, 8: return W_W'($urandom);
      default: begin
        if ($urandom_range(0, 1) == 0)
          return W_W'($urandom_range(0, 63));
        return W_ONE - W_W'($urandom_range(0, 63));
      end
    endcase
  endfunction

  task send_random(logic op, logic [1:0] level, logic [W_W-1:0] weight);
    idle_for(draw_gap());
    send_beat(op, level, weight);
  endtask

  // Check every strobed result as the rising edge ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1)
      ledger.match_result(result_o);
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("tb_smoothstep_polynomial_eval_unit: errors");
    $finish;
  end

  initial begin
    spe_prog_e prog;
    start_i  = 1'b0;
    op_i     = 1'b0;
    level_i  = 2'd0;
    weight_i = '0;
    rst_ni   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: both ends of the weight range on every program
    for (int p = 0; p < 8; p++) begin
      prog = spe_prog_e'(p);
      send_random(prog[2], prog[1:0], '0);
      send_random(prog[2], prog[1:0], W_ONE);
    end
    // Saturation above one, linear derivative off a wild weight, septic peak,
    // and the smallest steps off both ends
    send_random(PROG_V_SEP[2], PROG_V_SEP[1:0], '1);
    send_random(PROG_D_QUI[2], PROG_D_QUI[1:0], '1);
    send_random(PROG_D_CUB[2], PROG_D_CUB[1:0], W_ONE + W_W'(1));
    send_random(PROG_D_LIN[2], PROG_D_LIN[1:0], W_W'(17'h1ABCD));
    send_random(PROG_D_SEP[2], PROG_D_SEP[1:0], W_ONE >> 1);
    send_random(PROG_V_CUB[2], PROG_V_CUB[1:0], W_W'(1));
    send_random(PROG_V_QUI[2], PROG_V_QUI[1:0], W_ONE - W_W'(1));
    send_random(PROG_D_CUB[2], PROG_D_CUB[1:0], W_ONE - W_W'(1));

    // Random: any op, any level, weights spread over all 17 bits
    for (int i = 0; i < N_RAND; i++)
      send_random(1'($urandom), 2'($urandom), draw_weight());

    @(negedge clk_i);
    start_i <= 1'b0;

    // Drain the pipeline, then keep clocking so that a stray result would show
    while (ledger.pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (ledger.mismatches == 0)
      $display("tb_smoothstep_polynomial_eval_unit: clean");
    else
      $display("tb_smoothstep_polynomial_eval_unit: errors");
    $finish;
  end

endmodule

// ===== smoothstep_polynomial_eval_unit.f =====
+incdir+rtl
rtl/spe_pkg.sv
rtl/spe_seed.sv
rtl/spe_cell.sv
rtl/smoothstep_polynomial_eval_unit.sv
sim/tb_smoothstep_polynomial_eval_unit.sv
